FILE: hw/rtl/rbd_pkg.sv
// ----------------------------------------------------------------------------
// rbd_pkg
// Shared widths, register map, scan flags and channel arithmetic for the
// 2x2 RGBA box downsampler.
// ----------------------------------------------------------------------------
package rbd_pkg;

  localparam int PIX_W        = 32;
  localparam int CHAN_W       = 8;
  localparam int NCHAN        = 4;
  localparam int PSUM_W       = CHAN_W + 1;
  localparam int LINE_W       = NCHAN * PSUM_W;
  localparam int CFG_W        = 13;
  localparam int ROW_W        = 12;
  localparam int HEIGHT_LIMIT = 4096;
  localparam int MIN_DIM      = 2;
  localparam int APB_DW       = 32;
  localparam int APB_AW       = 3;
  localparam int DEF_MAX_WIDTH = 4096;

  typedef enum logic [0:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } rbd_reg_t;

  // Per-pixel decode of the scan position.
  typedef struct packed {
    logic hold;   // even column of an active pair
    logic wr;     // odd column, even row: store the pair sum
    logic rd;     // odd column, odd row: fetch the upper pair sum
    logic last;   // final block of the image
  } rbd_scan_t;

  function automatic logic [LINE_W-1:0] pair_sums(input logic [PIX_W-1:0] a,
                                                  input logic [PIX_W-1:0] b);
    logic [LINE_W-1:0] r;
    r = '0;
    for (int k = 0; k < NCHAN; k++) begin
      r[k*PSUM_W +: PSUM_W] = {1'b0, a[k*CHAN_W +: CHAN_W]} +
                              {1'b0, b[k*CHAN_W +: CHAN_W]};
    end
    return r;
  endfunction

  function automatic logic [PIX_W-1:0] box_mean(input logic [LINE_W-1:0] up,
                                                input logic [LINE_W-1:0] dn);
    logic [PIX_W-1:0]  r;
    logic [PSUM_W:0]   s;
    r = '0;
    for (int k = 0; k < NCHAN; k++) begin
      s = {1'b0, up[k*PSUM_W +: PSUM_W]} + {1'b0, dn[k*PSUM_W +: PSUM_W]};
      r[k*CHAN_W +: CHAN_W] = s[PSUM_W:2];
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/rbd_line_mem.sv
// ----------------------------------------------------------------------------
// rbd_line_mem
// Line store of pair sums: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module rbd_line_mem
  import rbd_pkg::*;
#(
  parameter int DEPTH = DEF_MAX_WIDTH / 2,
  parameter int AW    = $clog2(DEF_MAX_WIDTH / 2)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [LINE_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [LINE_W-1:0] rd_data
);

  logic [LINE_W-1:0] mem [DEPTH];
  logic [LINE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Hold the last read word until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hw/rtl/rbd_scan.sv
// ----------------------------------------------------------------------------
// rbd_scan
// Column and row counters of the raster scan with block position decode.
// ----------------------------------------------------------------------------
module rbd_scan
  import rbd_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int CW        = $clog2(MAX_WIDTH),
  parameter int AW        = $clog2(MAX_WIDTH) - 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             advance,
  input  logic             restart,
  input  logic [CFG_W-1:0] image_width,
  input  logic [CFG_W-1:0] image_height,
  output rbd_scan_t        scan,
  output logic [AW-1:0]    line_idx
);

  localparam int EWW  = $clog2(MAX_WIDTH + 1);
  localparam int CMPW = (CFG_W > EWW) ? CFG_W : EWW;
  localparam int EHW  = ROW_W + 1;

  logic [CW-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [CMPW-1:0]  w_ext;
  logic [EWW-1:0]   w_eff, ew, col_x;
  logic [EHW-1:0]   h_eff, eh, row_x;
  logic             active, col_end, row_end, pair_end;

  // Saturate the programmed sizes.
  always_comb begin
    w_ext = CMPW'(image_width);
    if (w_ext < CMPW'(MIN_DIM)) begin
      w_eff = EWW'(MIN_DIM);
    end else if (w_ext > CMPW'(MAX_WIDTH)) begin
      w_eff = EWW'(MAX_WIDTH);
    end else begin
      w_eff = w_ext[EWW-1:0];
    end
    if (image_height < CFG_W'(MIN_DIM)) begin
      h_eff = EHW'(MIN_DIM);
    end else if (image_height > CFG_W'(HEIGHT_LIMIT)) begin
      h_eff = EHW'(HEIGHT_LIMIT);
    end else begin
      h_eff = image_height[EHW-1:0];
    end
  end

  assign ew      = {w_eff[EWW-1:1], 1'b0};
  assign eh      = {h_eff[EHW-1:1], 1'b0};
  assign col_x   = EWW'(col_r);
  assign row_x   = EHW'(row_r);
  assign active  = (col_x < ew) && (row_x < eh);
  assign col_end = (col_x == w_eff - EWW'(1));
  assign row_end = (row_x == h_eff - EHW'(1));
  assign pair_end = (col_x + EWW'(1) == ew) && (row_x + EHW'(1) == eh);

  always_comb begin
    scan.hold = active && !col_r[0];
    scan.wr   = active && col_r[0] && !row_r[0];
    scan.rd   = active && col_r[0] && row_r[0];
    scan.last = pair_end;
  end

  assign line_idx = col_r[CW-1:1];

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (advance) begin
      if (col_end) begin
        col_nxt = '0;
        row_nxt = row_end ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

FILE: hw/rtl/rgba_box_downsample_2x2_core.sv
// ----------------------------------------------------------------------------
// rgba_box_downsample_2x2_core
// A block's mean goes from its fourth accepted pixel through s1 to the output register.
// Throughput: one pixel per cycle, sustained while out_tready holds high.
// The line store has one read and one write port; each pixel uses at most one.
// Reset (rst_n low, synchronous): width and height return to 2, scan restarts
// at row 0 column 0, pipeline empties. The line store is not cleared.
// ----------------------------------------------------------------------------
// 2x2 box downsampler for packed RGBA8 pixels. Even rows store per-channel
// horizontal pair sums in the line store; on the odd row the matching entry
// is read back, added to the new pair sum and divided by four (truncating).
// A trailing odd column or row is consumed without output.
//
// Pipeline:
//   accept : decode scan position, hold even-column pixel, form pair sum,
//            write (even row) or read (odd row) the line store
//   s1     : pair sum waits for the registered line store word
//   out    : averaged pixel register facing the output channel
// An even-row entry is always written at least one row before it is read,
// so reads and writes never collide on the same entry.
module rgba_box_downsample_2x2_core
  import rbd_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic              clk,
  input  logic              rst_n,
  // input stream
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [PIX_W-1:0]  in_tdata,    // [31:0] pixel_in
  // result stream
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [PIX_W-1:0]  out_tdata,   // [31:0] pixel_out
  output logic              out_tlast,   // last_of_image
  // configuration
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [APB_AW-1:0] cfg_paddr,
  input  logic [APB_DW-1:0] cfg_pwdata,
  output logic [APB_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int AW    = CW - 1;
  localparam int DEPTH = MAX_WIDTH / 2;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [CFG_W-1:0] width_r, height_r;
  logic             cfg_wr;
  rbd_reg_t         cfg_sel;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_sel    = rbd_reg_t'(cfg_paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CFG_W'(MIN_DIM);
      height_r <= CFG_W'(MIN_DIM);
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_WIDTH:  width_r  <= cfg_pwdata[CFG_W-1:0];
        REG_HEIGHT: height_r <= cfg_pwdata[CFG_W-1:0];
        default:    width_r  <= width_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_WIDTH:  cfg_prdata = APB_DW'(width_r);
      REG_HEIGHT: cfg_prdata = APB_DW'(height_r);
      default:    cfg_prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Scan position
  // --------------------------------------------------------------------------
  rbd_scan_t     scan;
  logic [AW-1:0] line_idx;
  logic          in_acc;

  // Any register write restarts the image.
  rbd_scan #(
    .MAX_WIDTH (MAX_WIDTH),
    .CW        (CW),
    .AW        (AW)
  ) u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .advance      (in_acc),
    .restart      (cfg_wr),
    .image_width  (width_r),
    .image_height (height_r),
    .scan         (scan),
    .line_idx     (line_idx)
  );

  // --------------------------------------------------------------------------
  // Accept stage: pair sum and line store access
  // --------------------------------------------------------------------------
  logic [PIX_W-1:0]  held_r;
  logic [LINE_W-1:0] pair_sum;
  logic [LINE_W-1:0] up_sum;
  logic              s1_valid_r, s1_valid_nxt;
  logic [LINE_W-1:0] s1_sum_r;
  logic              s1_last_r;
  logic              out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0]  out_pix_r;
  logic              out_last_r;
  logic              s1_move;

  // Take a new request whenever s1 is free or drains this cycle; an
  // occupied output register alone never stalls the input.
  assign s1_move   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign pair_sum  = pair_sums(held_r, in_tdata);

  // Hold the even-column pixel of the current pair.
  always_ff @(posedge clk) begin
    if (in_acc && scan.hold) begin
      held_r <= in_tdata;
    end
  end

  rbd_line_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_line (
    .clk     (clk),
    .wr_en   (in_acc && scan.wr),
    .wr_addr (line_idx),
    .wr_data (pair_sum),
    .rd_en   (in_acc && scan.rd),
    .rd_addr (line_idx),
    .rd_data (up_sum)
  );

  // --------------------------------------------------------------------------
  // s1: wait for the upper pair sum. The line store keeps its read word
  // until the next read, and no read is issued while s1 is stuck.
  // --------------------------------------------------------------------------
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc && scan.rd) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && scan.rd) begin
      s1_sum_r  <= pair_sum;
      s1_last_r <= scan.last;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_move) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_pix_r  <= box_mean(up_sum, s1_sum_r);
      out_last_r <= s1_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_pix_r;
  assign out_tlast  = out_last_r;

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 2x2 RGBA box downsampler. Pixels stream in
// through the input channel while the bench mirrors the scan, the line store
// of pair sums and the truncating per-channel mean. Every produced mean is
// compared with the oldest predicted one, field by field. Image sizes are set
// over the APB port: defaults, odd sizes, saturated extremes, one long output
// stall, then random sizes with random handshake gaps.
// ----------------------------------------------------------------------------
module testbench
  import rbd_pkg::*;
;

  localparam int MAX_W          = DEF_MAX_WIDTH;
  localparam int LINE_DEPTH     = MAX_W / 2;
  localparam int RANDOM_ITEMS   = 1000;
  localparam int SETTLE_CYCLES  = 8;     // pipeline is 2 deep; allow margin
  localparam int DRAIN_CYCLES   = 16;
  localparam int HOLD_CYCLES    = 600;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             last;
  } box_mean_t;

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              in_tvalid   = 1'b0;
  logic              in_tready;
  logic [PIX_W-1:0]  in_tdata    = '0;   // [31:0] pixel_in
  logic              out_tvalid;
  logic              out_tready  = 1'b0;
  logic [PIX_W-1:0]  out_tdata;          // [31:0] pixel_out
  logic              out_tlast;          // last_of_image
  logic              cfg_psel    = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite  = 1'b0;
  logic [APB_AW-1:0] cfg_paddr   = '0;
  logic [APB_DW-1:0] cfg_pwdata  = '0;
  logic [APB_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  // Mirror of the block: registers, scan position, held pixel, line store.
  logic [CFG_W-1:0]  width_reg  = CFG_W'(MIN_DIM);
  logic [CFG_W-1:0]  height_reg = CFG_W'(MIN_DIM);
  int unsigned       scan_col   = 0;
  int unsigned       scan_row   = 0;
  logic [PIX_W-1:0]  held_pix   = '0;
  logic [LINE_W-1:0] line_sums [LINE_DEPTH];

  box_mean_t pending_means [$];

  int  errors         = 0;
  int  pixels_sent    = 0;
  int  means_checked  = 0;
  int  images_closed  = 0;
  int  size_settings  = 0;
  int  random_items   = 0;
  int  idle_cycles    = 0;
  bit  gaps_on        = 1'b0;
  bit  rx_stalls_on   = 1'b0;
  int  hold_off_req   = 0;
  int  hold_left      = 0;
  int  stall_left     = 0;

  rgba_box_downsample_2x2_core #(
    .MAX_WIDTH(MAX_W)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #1 clk = ~clk;

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap(input bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Full random word; a quarter of the time force some channels to 00 or ff.
  function automatic logic [PIX_W-1:0] rand_pixel();
    logic [PIX_W-1:0] p;
    p = $urandom;
    if ($urandom_range(0, 3) == 0) begin
      for (int k = 0; k < NCHAN; k++) begin
        case ($urandom_range(0, 2))
          0: p[k*CHAN_W +: CHAN_W] = '0;
          1: p[k*CHAN_W +: CHAN_W] = '1;
          default: ;
        endcase
      end
    end
    return p;
  endfunction

  // Advance the mirrored scan by one accepted pixel and queue the mean it
  // completes, if any.
  task automatic downsample_pixel(input logic [PIX_W-1:0] pix);
    int unsigned       w, h, ew, eh, idx;
    logic [LINE_W-1:0] pair;
    logic [PSUM_W:0]   quad;
    box_mean_t         m;
    // Saturate the programmed sizes, then drop a trailing odd column or row.
    w  = (width_reg < MIN_DIM) ? MIN_DIM : ((width_reg > MAX_W) ? MAX_W : width_reg);
    h  = (height_reg < MIN_DIM) ? MIN_DIM :
         ((height_reg > HEIGHT_LIMIT) ? HEIGHT_LIMIT : height_reg);
    ew = w - (w % 2);
    eh = h - (h % 2);
    if (scan_col < ew && scan_row < eh) begin
      if (scan_col % 2 == 0) begin
        held_pix = pix;
      end else begin
        idx = (scan_col / 2) % LINE_DEPTH;
        for (int k = 0; k < NCHAN; k++) begin
          pair[k*PSUM_W +: PSUM_W] = {1'b0, held_pix[k*CHAN_W +: CHAN_W]} +
                                     {1'b0, pix[k*CHAN_W +: CHAN_W]};
        end
        if (scan_row % 2 == 0) begin
          line_sums[idx] = pair;
        end else begin
          m.pixel = '0;
          for (int k = 0; k < NCHAN; k++) begin
            quad = {1'b0, line_sums[idx][k*PSUM_W +: PSUM_W]} +
                   {1'b0, pair[k*PSUM_W +: PSUM_W]};
            m.pixel[k*CHAN_W +: CHAN_W] = quad[PSUM_W:2];
          end
          m.last = (scan_col + 1 == ew) && (scan_row + 1 == eh);
          pending_means.push_back(m);
        end
      end
    end
    scan_col++;
    if (scan_col >= w) begin
      scan_col = 0;
      scan_row++;
      if (scan_row >= h) scan_row = 0;
    end
  endtask

  // Offer one pixel, optionally after an idle gap; hold it until the request
  // is taken, then update the mirror.
  task automatic send_pixel(input logic [PIX_W-1:0] pix);
    int gap;
    gap = pick_gap(gaps_on);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pix;
    do @(posedge clk); while (!in_tready);
    pixels_sent++;
    downsample_pixel(pix);
  endtask

  task automatic send_random_pixels(input int count);
    for (int i = 0; i < count; i++) send_pixel(rand_pixel());
  endtask

  // Drop the input request and let every expected mean drain, then give the
  // pipeline time to swallow pixels that produce nothing.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; the write lands on the access edge.
  task automatic write_reg(input rbd_reg_t r, input logic [APB_DW-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {r, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    // Any write restarts the image; the line store keeps its contents.
    if (r == REG_WIDTH) width_reg = value[CFG_W-1:0];
    else                height_reg = value[CFG_W-1:0];
    scan_col = 0;
    scan_row = 0;
    // Leave the bus idle before the next transfer.
    @(posedge clk);
  endtask

  task automatic read_check_reg(input rbd_reg_t r);
    logic [APB_DW-1:0] want;
    want = APB_DW'((r == REG_WIDTH) ? width_reg : height_reg);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= {r, 2'b00};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== want) begin
      $display("%0t: register %s read expected %h actual %h", $time, r.name(), want,
               cfg_prdata);
      errors++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input int w, input int h);
    wait_idle();
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    size_settings++;
  endtask

  // Default 2x2 image: all-ones block, then a block whose channel sums of 3
  // truncate to zero, which also checks the wrap to the next image.
  task automatic test_reset_defaults();
    read_check_reg(REG_WIDTH);
    read_check_reg(REG_HEIGHT);
    repeat (4) send_pixel('1);
    send_pixel(32'h0101_0101);
    send_pixel(32'h0101_0101);
    send_pixel(32'h0101_0101);
    send_pixel(32'h0000_0000);
  endtask

  // 4x2 image: alternating channel extremes, then a block rounding 1019 down.
  task automatic test_channel_extremes();
    logic [PIX_W-1:0] pix [8];
    pix = '{32'hff00_ff00, 32'h00ff_00ff, 32'hffff_ffff, 32'hfeff_fffe,
            32'h00ff_00ff, 32'hff00_ff00, 32'hffff_ffff, 32'hffff_ffff};
    configure(4, 2);
    foreach (pix[i]) send_pixel(pix[i]);
  endtask

  // 3x3 image: trailing odd column and odd row are consumed silently.
  task automatic test_odd_dims();
    configure(3, 3);
    send_pixel(32'h8000_0001);
    send_pixel(32'h7fff_fffe);
    send_pixel(32'hdead_beef);
    send_pixel(32'h0123_4567);
    send_pixel(32'hfedc_ba98);
    send_pixel(32'hcafe_f00d);
    send_pixel(32'h5555_aaaa);
    send_pixel(32'haaaa_5555);
    send_pixel(32'h0f0f_f0f0);
  endtask

  // Out-of-range sizes saturate: below to 2, above to the largest size.
  task automatic test_saturation();
    gaps_on      = 1'b1;
    rx_stalls_on = 1'b1;
    configure(0, 1);
    read_check_reg(REG_WIDTH);
    read_check_reg(REG_HEIGHT);
    send_random_pixels(8);
    configure(1, 0);
    send_random_pixels(8);
    // Widest setting: start of the first row, no means due yet.
    configure(32'hffff_ffff, 1);
    read_check_reg(REG_WIDTH);
    send_random_pixels(16);
    // Tallest setting, two columns: the first rows of the image.
    configure(1, 32'h0000_1fff);
    read_check_reg(REG_HEIGHT);
    send_random_pixels(64);
  endtask

  // Stall the output for a long stretch while pixels keep coming, so the
  // block fills up and must drop in_tready.
  task automatic test_backpressure();
    gaps_on      = 1'b0;
    rx_stalls_on = 1'b0;
    configure(16, 8);
    hold_off_req = HOLD_CYCLES;
    send_random_pixels(2 * 16 * 8);
  endtask

  // Random sizes, mostly small, mostly whole images, some cut short.
  task automatic test_random_images();
    int w, h, n;
    while (random_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 6) == 0) begin
        w = $urandom_range(2, 64);
        h = $urandom_range(2, 16);
      end else begin
        w = $urandom_range(2, 12);
        h = $urandom_range(2, 10);
      end
      gaps_on      = ($urandom_range(0, 3) != 0);
      rx_stalls_on = ($urandom_range(0, 3) != 0);
      configure(w, h);
      n = $urandom_range(1, 3) * w * h;
      // Abort the image part way; the next size write restarts the scan.
      if ($urandom_range(0, 5) == 0) n = $urandom_range(1, w * h - 1);
      // Stay within the item budget.
      if (n > RANDOM_ITEMS - random_items) n = RANDOM_ITEMS - random_items;
      send_random_pixels(n);
      random_items += n;
    end
  endtask

  // Receiver: honor a requested hold-off first, else random stalls.
  always @(posedge clk) begin
    if (hold_off_req != 0) begin
      hold_left    = hold_off_req;
      hold_off_req = 0;
    end
    if (hold_left != 0) begin
      hold_left  = hold_left - 1;
      out_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left = stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      stall_left = pick_gap(rx_stalls_on);
    end
  end

  // Compare every accepted mean with the oldest prediction.
  always @(posedge clk) begin
    box_mean_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_means.size() == 0) begin
        $display("%0t: unexpected mean, expected none actual pixel %h last %b", $time,
                 out_tdata, out_tlast);
        errors++;
      end else begin
        want = pending_means.pop_front();
        means_checked++;
        if (out_tdata !== want.pixel) begin
          $display("%0t: pixel_out mismatch expected %h actual %h", $time, want.pixel,
                   out_tdata);
          errors++;
        end
        if (out_tlast !== want.last) begin
          $display("%0t: last_of_image mismatch expected %b actual %b", $time,
                   want.last, out_tlast);
          errors++;
        end
        if (want.last) images_closed++;
      end
    end
  end

  // Watchdog: give up after a long run of cycles in which nothing moves.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, %0d means still expected", $time, pending_means.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_channel_extremes();
    test_odd_dims();
    test_saturation();
    test_backpressure();
    test_random_images();

    // Drain what is still in flight and watch for stray output.
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d pixels over %0d size settings; checked %0d means, %0d image ends.",
             pixels_sent, size_settings, means_checked, images_closed);
    $display("Covered default, odd, saturated and random sizes with gaps and a long stall.");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
